### hdl/epid_pkg.sv
// package: constants, opcodes and beat payload types for the encoder position block
`default_nettype none
package epid_pkg;

   localparam int TIMER_BITS     = 16;
   localparam int POS_BITS       = 32;
   localparam int DRIFT_BITS     = 16;
   localparam int TIMER_SHIFT    = 16;   // log2 of a timer span of 65536
   localparam int INDEX_SHIFT    = 10;   // log2 of 1024 counts per index
   localparam logic [DRIFT_BITS-1:0] THRESHOLD_RESET = 16'd16;

   typedef enum logic [2:0] {
      OP_WRAP_UP   = 3'd0,
      OP_WRAP_DOWN = 3'd1,
      OP_INDEX     = 3'd2,
      OP_SET_POS   = 3'd3,
      OP_RESET     = 3'd4
   } opcode_type;

   typedef struct packed {
      logic        [2:0]            opcode;
      logic        [TIMER_BITS-1:0] timer_count;
      logic signed [POS_BITS-1:0]   new_position;
   } req_type;

   typedef struct packed {
      logic signed [POS_BITS-1:0]   position;
      logic        [TIMER_BITS-1:0] timer_load;
      logic                         timer_load_valid;
      logic signed [POS_BITS-1:0]   index_position;
      logic                         first_index_seen;
      logic        [POS_BITS-1:0]   index_pulses;
      logic                         drift_detected;
      logic signed [DRIFT_BITS-1:0] drift_error;
   } rsp_type;

   typedef logic [DRIFT_BITS-1:0] csr_type;

endpackage
`default_nettype wire

### hdl/epid_stream_if.sv
// interface: valid/ready channel carrying one payload per beat
`default_nettype none
interface epid_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/encoder_position_index_drift_top.sv
// top level: encoder position extension with index drift check
//
// channels: req_ch takes one event beat (opcode, timer sample, target position),
// rsp_ch returns exactly one result beat per event, csr_ch writes the 16-bit
// drift threshold (always ready, write only while the block is idle).
// latency: the result of an event is offered on rsp_ch the cycle after the
// event beat is taken. throughput: one event per cycle unless rsp_ch stalls;
// the state update and the result are computed in one pass from the beat and
// the state registers. a result register sits on rsp_ch; req_ch.ready is high
// while that register is empty or being drained, so a new event is taken in
// the same cycle that the previous result leaves. when the receiver stalls,
// the result holds and req_ch.ready drops until it is taken.
// reset: synchronous, active high. wraps, index tracking and drift state
// clear, the threshold returns to 16 and no result is pending.
// a reset event on req_ch clears the same state except the first index
// position and the threshold, and asks the timer to load zero.
`default_nettype none
module encoder_position_index_drift_top (
   input  wire logic     clock,
   input  wire logic     reset,
   epid_stream_if.sink   req_ch,
   epid_stream_if.source rsp_ch,
   epid_stream_if.sink   csr_ch
);
   import epid_pkg::*;

   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff, rsp_data_in;
   logic        [DRIFT_BITS-1:0] threshold_ff;
   logic        [POS_BITS-1:0]   wrap_count_ff, wrap_count_in;
   logic        [POS_BITS-1:0]   captured_ff, captured_in;
   logic        [POS_BITS-1:0]   first_pos_ff, first_pos_in;
   logic                         first_seen_ff, first_seen_in;
   logic        [POS_BITS-1:0]   pulse_count_ff, pulse_count_in;
   logic                         drift_flag_ff, drift_flag_in;
   logic        [DRIFT_BITS-1:0] drift_value_ff, drift_value_in;

   req_type                      req;
   logic                         req_beat;
   logic        [POS_BITS-1:0]   wrap_base;
   logic        [POS_BITS-1:0]   pos_sample;
   logic        [POS_BITS-1:0]   pos;
   logic        [TIMER_BITS-1:0] load;
   logic                         load_valid;
   logic        [POS_BITS-1:0]   expected;
   logic        [DRIFT_BITS-1:0] diff;
   logic        [DRIFT_BITS-1:0] mag;

   assign req        = req_ch.data;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_beat   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_comb begin
      wrap_count_in  = wrap_count_ff;
      captured_in    = captured_ff;
      first_pos_in   = first_pos_ff;
      first_seen_in  = first_seen_ff;
      pulse_count_in = pulse_count_ff;
      drift_flag_in  = drift_flag_ff;
      drift_value_in = drift_value_ff;
      load           = '0;
      load_valid     = 1'b0;
      wrap_base      = wrap_count_ff;
      expected       = '0;
      diff           = '0;
      mag            = '0;

      case (opcode_type'(req.opcode))
         OP_WRAP_UP: begin
            wrap_count_in = wrap_count_ff + POS_BITS'(1);
            wrap_base     = wrap_count_in;
         end
         OP_WRAP_DOWN: begin
            wrap_count_in = wrap_count_ff - POS_BITS'(1);
            wrap_base     = wrap_count_in;
         end
         OP_SET_POS: begin
            wrap_count_in = POS_BITS'($signed(req.new_position) >>> TIMER_SHIFT);
            wrap_base     = wrap_count_in;
            load          = TIMER_BITS'(req.new_position[TIMER_SHIFT-1:0]);
            load_valid    = 1'b1;
         end
         OP_RESET: begin
            wrap_count_in  = '0;
            wrap_base      = '0;
            captured_in    = '0;
            first_seen_in  = 1'b0;
            pulse_count_in = '0;
            drift_flag_in  = 1'b0;
            drift_value_in = '0;
            load_valid     = 1'b1;
         end
         default: begin
         end
      endcase

      pos_sample = (wrap_base << TIMER_SHIFT) + POS_BITS'(req.timer_count);
      pos        = load_valid ? ((wrap_base << TIMER_SHIFT) + POS_BITS'(load)) : pos_sample;

      if (opcode_type'(req.opcode) == OP_INDEX) begin
         captured_in = pos_sample;
         if (!first_seen_ff) begin
            first_pos_in   = pos_sample;
            first_seen_in  = 1'b1;
            pulse_count_in = '0;
         end else begin
            pulse_count_in = pulse_count_ff + POS_BITS'(1);
            expected       = first_pos_ff + (pulse_count_in << INDEX_SHIFT);
            diff           = DRIFT_BITS'(pos_sample - expected);
            mag            = diff[DRIFT_BITS-1] ? (~diff + DRIFT_BITS'(1)) : diff;
            if (mag > threshold_ff) begin
               drift_flag_in  = 1'b1;
               drift_value_in = diff;
            end
         end
      end

      rsp_data_in.position         = pos;
      rsp_data_in.timer_load       = load;
      rsp_data_in.timer_load_valid = load_valid;
      rsp_data_in.index_position   = captured_in;
      rsp_data_in.first_index_seen = first_seen_in;
      rsp_data_in.index_pulses     = pulse_count_in;
      rsp_data_in.drift_detected   = drift_flag_in;
      rsp_data_in.drift_error      = drift_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         threshold_ff   <= THRESHOLD_RESET;
         wrap_count_ff  <= '0;
         captured_ff    <= '0;
         first_pos_ff   <= '0;
         first_seen_ff  <= 1'b0;
         pulse_count_ff <= '0;
         drift_flag_ff  <= 1'b0;
         drift_value_ff <= '0;
      end else begin
         if (csr_ch.valid) begin
            threshold_ff <= csr_ch.data;
         end
         if (req_beat) begin
            rsp_valid_ff   <= 1'b1;
            wrap_count_ff  <= wrap_count_in;
            captured_ff    <= captured_in;
            first_pos_ff   <= first_pos_in;
            first_seen_ff  <= first_seen_in;
            pulse_count_ff <= pulse_count_in;
            drift_flag_ff  <= drift_flag_in;
            drift_value_ff <= drift_value_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_beat_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_ch.valid)
      else $error("accepted event produced no result");

   a_drift_sticky: assert property (@(posedge clock) disable iff (reset)
      (drift_flag_ff && !(req_beat && req.opcode == OP_RESET)) |=> drift_flag_ff)
      else $error("drift flag cleared without reset event");

   a_pulses_before_first: assert property (@(posedge clock) disable iff (reset)
      !first_seen_ff |-> (pulse_count_ff == '0))
      else $error("pulse count nonzero before first index");

   a_load_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.data.timer_load_valid) |-> (rsp_ch.data.timer_load == '0))
      else $error("timer load nonzero without load request");

endmodule
`default_nettype wire
